/* rtl/bnse_pkg.sv */
`default_nettype none
package bnse_pkg;

  localparam int MAX_SYMBOL_BITS = 8;
  localparam int SYM_W = 4;
  localparam int CHAR_W = 8;
  localparam int TABLE_AW = 8;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int LVL_W = FIFO_AW + 1;

  localparam logic [SYM_W-1:0] SYMBOL_BITS_RESET = 4'd6;
  localparam logic [CHAR_W-1:0] PAD_CHAR_RESET = 8'd61;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_BITS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_CHAR = 8'd1;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_LOAD = 2'd1;
  localparam logic [1:0] MODE_END = 2'd2;

  typedef enum logic [1:0] {
    JOB_IDLE,
    JOB_DATA,
    JOB_END
  } job_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] table_index;
    logic [7:0] table_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol_char;
    logic       is_pad;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic                 en;
    logic [TABLE_AW-1:0]  addr;
    logic [CHAR_W-1:0]    data;
  } ram_wr_t;

  typedef struct packed {
    logic              valid;
    logic              is_pad;
    logic              last;
    logic [CHAR_W-1:0] pad_char;
  } issue_t;

  function automatic logic [2:0] frac8(input logic [2:0] c, input logic [SYM_W-1:0] kk);
    logic [6:0] p;
    p = 7'(c) * 7'(kk);
    return p[2:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/bnse_ram.sv */
`default_nettype none
module bnse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write to one address in the same cycle return the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/bnse_seq.sv */
`default_nettype none
module bnse_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bnse_pkg::cfg_wr_t  cfg,
  input  wire logic               in_valid,
  input  wire bnse_pkg::in_item_t in_item,
  output logic                    in_ready,
  input  wire logic               space,
  output bnse_pkg::issue_t        iss,
  output logic [7:0]              rd_addr,
  output bnse_pkg::ram_wr_t       wr
);
  import bnse_pkg::*;

  job_t              job, job_next;
  logic [15:0]       holder, holder_next;
  logic [3:0]        held, held_next;
  logic [2:0]        count, count_next;
  logic [SYM_W-1:0]  sym_bits, sym_bits_next;
  logic [CHAR_W-1:0] pad_char, pad_char_next;

  logic [SYM_W-1:0]  k;
  logic [8:0]        kmask_w;
  logic [7:0]        kmask;
  logic [3:0]        held_d;
  logic [15:0]       gshift;
  logic [15:0]       keep_mask;
  logic [15:0]       gleft;
  logic [7:0]        g_data;
  logic [7:0]        g_fin;
  logic [15:0]       holder_d;
  logic [2:0]        count1;
  logic              fin;
  logic              pad_need;
  logic              have;
  logic              is_last;
  logic              do_issue;
  logic              finishing;
  logic              accept;
  logic [15:0]       holder_a;
  logic [3:0]        held_a;
  logic [2:0]        count_a;

  always_comb begin
    if (sym_bits == '0) begin
      k = SYM_W'(1);
    end else if (sym_bits > SYM_W'(MAX_SYMBOL_BITS)) begin
      k = SYM_W'(MAX_SYMBOL_BITS);
    end else begin
      k = sym_bits;
    end
  end

  assign kmask_w   = (9'd1 << k) - 9'd1;
  assign kmask     = kmask_w[7:0];
  assign held_d    = held - k;
  assign gshift    = holder >> held_d;
  assign g_data    = gshift[7:0] & kmask;
  assign keep_mask = (16'd1 << held_d) - 16'd1;
  assign holder_d  = holder & keep_mask;
  assign gleft     = holder << (k - held);
  assign g_fin     = gleft[7:0] & kmask;
  assign count1    = count + 3'd1;
  assign fin       = (held != '0) && (held < k);
  assign pad_need  = frac8(count, k) != '0;

  always_comb begin
    have     = 1'b0;
    is_last  = 1'b0;
    rd_addr  = g_data;
    iss      = '0;
    holder_a = holder;
    held_a   = held;
    count_a  = count;
    job_next = job;
    wr       = '0;
    sym_bits_next = sym_bits;
    pad_char_next = pad_char;

    unique case (job)
      JOB_DATA: begin
        have    = held >= k;
        is_last = held_d < k;
      end
      JOB_END: begin
        have    = fin || pad_need;
        is_last = frac8(count1, k) == '0;
        if (fin) begin
          rd_addr = g_fin;
        end
      end
      default: begin
        have = 1'b0;
      end
    endcase

    do_issue  = have && space;
    finishing = (job != JOB_IDLE) && (!have || (do_issue && is_last));
    in_ready  = (job == JOB_IDLE) || finishing;
    accept    = in_valid && in_ready;

    iss.valid    = do_issue;
    iss.is_pad   = (job == JOB_END) && !fin;
    iss.last     = is_last;
    iss.pad_char = pad_char;

    if (do_issue) begin
      count_a = count1;
      if (job == JOB_DATA) begin
        holder_a = holder_d;
        held_a   = held_d;
      end else if (fin) begin
        holder_a = '0;
        held_a   = '0;
      end
    end
    if (finishing) begin
      job_next = JOB_IDLE;
      if (job == JOB_END) begin
        holder_a = '0;
        held_a   = '0;
        count_a  = '0;
      end
    end

    holder_next = holder_a;
    held_next   = held_a;
    count_next  = count_a;

    if (accept) begin
      unique case (in_item.mode)
        MODE_BYTE: begin
          holder_next = {holder_a[7:0], in_item.data_byte};
          held_next   = held_a + 4'd8;
          job_next    = JOB_DATA;
        end
        MODE_END: begin
          job_next = JOB_END;
        end
        MODE_LOAD: begin
          wr.en   = 1'b1;
          wr.addr = in_item.table_index;
          wr.data = in_item.table_char;
        end
        default: begin
          wr.en = 1'b0;
        end
      endcase
    end

    if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SYMBOL_BITS: begin
          sym_bits_next = cfg.data[SYM_W-1:0];
          holder_next   = '0;
          held_next     = '0;
          count_next    = '0;
        end
        CFG_PAD_CHAR: begin
          pad_char_next = cfg.data;
        end
        default: begin
          pad_char_next = pad_char;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job      <= JOB_IDLE;
      holder   <= '0;
      held     <= '0;
      count    <= '0;
      sym_bits <= SYMBOL_BITS_RESET;
      pad_char <= PAD_CHAR_RESET;
    end else begin
      job      <= job_next;
      holder   <= holder_next;
      held     <= held_next;
      count    <= count_next;
      sym_bits <= sym_bits_next;
      pad_char <= pad_char_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/bnse_outq.sv */
`default_nettype none
module bnse_outq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire bnse_pkg::out_item_t push_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bnse_pkg::out_item_t      out_item,
  output logic [bnse_pkg::LVL_W-1:0] level
);
  import bnse_pkg::*;

  out_item_t          entry [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic               pop;

  assign out_valid = level != '0;
  assign out_item  = entry[rptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + FIFO_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + FIFO_AW'(1);
      end
      level <= level + LVL_W'(push) - LVL_W'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/base_n_symbol_encoder.sv */
`default_nettype none
// The first character of an item is issued from the sequencer state, passes the read stage
// beside the alphabet memory and is written into the output queue before it reaches the output.
// One character per cycle while the queue has room; the next item is taken as the last character
// of the current one issues. The symbol sequencer sets the rate, with at most one alphabet read per cycle.
// Reset is synchronous and active high: symbol size returns to 6, padding to '=', the message
// state clears; the alphabet memory keeps its contents and is undefined until written.
module base_n_symbol_encoder (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bnse_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bnse_pkg::out_item_t      out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [bnse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bnse_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bnse_pkg::*;

  cfg_wr_t           cfg;
  issue_t            iss;
  ram_wr_t           wr;
  logic [7:0]        rd_addr;
  logic [7:0]        ram_rdata;
  logic              space;
  logic [LVL_W-1:0]  level;
  out_item_t         push_item;

  // Read stage: travels alongside the alphabet memory's registered read.
  logic              r_valid;
  logic              r_is_pad;
  logic              r_last;
  logic [CHAR_W-1:0] r_pad;

  // Configuration writes are always taken; the user must send them only while the block is idle; it is not enforced.
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // A character is issued only when the output queue has room for it and for the one
  // already in the read stage, so the read stage never has to stall.
  assign space = (level + LVL_W'(r_valid)) < LVL_W'(FIFO_DEPTH);

  bnse_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_ready (in_ready),
    .space    (space),
    .iss      (iss),
    .rd_addr  (rd_addr),
    .wr       (wr)
  );

  // The alphabet memory is read-first, so a load that follows the last read of the previous
  // item in the same cycle does not disturb that read.
  bnse_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_alphabet (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= iss.valid;
    end
  end

  always_ff @(posedge clk) begin
    r_is_pad <= iss.is_pad;
    r_last   <= iss.last;
    r_pad    <= iss.pad_char;
  end

  assign push_item.symbol_char = r_is_pad ? r_pad : ram_rdata;
  assign push_item.is_pad      = r_is_pad;
  assign push_item.last        = r_last;

  bnse_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (r_valid),
    .push_item (push_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .level     (level)
  );

`ifndef ASSERT_OFF
  // The queue never receives a character it has no room for.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> (level < LVL_W'(FIFO_DEPTH)))
    else $error("output queue overflow");

  // Queued and in-flight characters together never exceed the queue depth.
  a_credit: assert property (@(posedge clk) disable iff (rst)
    (level + LVL_W'(r_valid)) <= LVL_W'(FIFO_DEPTH))
    else $error("credit accounting broken");

  // Issuing an item's last character frees the input for the next item.
  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (iss.valid && iss.last) |-> in_ready)
    else $error("input not ready after last character");
`endif

endmodule
`default_nettype wire
